// ----- hdl/bcrtc_pkg.sv -----
package bcrtc_pkg;

  localparam int ROM_CNT_W  = 10;
  localparam int RAM_CNT_W  = 5;
  localparam int ROM_BANK_W = 7;
  localparam int RAM_BANK_W = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int LATCH_DEPTH = 5;
  localparam int RTC_SEL_W   = 3;
  localparam int DIV_STEPS   = ROM_BANK_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROM_BANK_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANK_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_PRESENT  = 2'd2;

  localparam logic [2:0] AREA_RAM_EN  = 3'd0;
  localparam logic [2:0] AREA_ROM_SEL = 3'd1;
  localparam logic [2:0] AREA_WIN_SEL = 3'd2;
  localparam logic [2:0] AREA_LATCH   = 3'd3;
  localparam logic [2:0] AREA_WINDOW  = 3'd5;

  localparam logic [RTC_SEL_W-1:0] SEL_SECONDS   = 3'd0;
  localparam logic [RTC_SEL_W-1:0] SEL_MINUTES   = 3'd1;
  localparam logic [RTC_SEL_W-1:0] SEL_HOURS     = 3'd2;
  localparam logic [RTC_SEL_W-1:0] SEL_DAYS_LOW  = 3'd3;
  localparam logic [RTC_SEL_W-1:0] SEL_DAYS_HIGH = 3'd4;
  localparam logic [RTC_SEL_W-1:0] SEL_NONE      = 3'd7;

  localparam logic [7:0] MASK_DAYS_HIGH = 8'hC1;
  localparam logic [7:0] BYTE_ONES      = 8'hFF;
  localparam logic [3:0] RAM_EN_KEY     = 4'hA;
  localparam int         HALT_BIT       = 6;
  localparam int         CARRY_BIT      = 7;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] address;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic                  handled;
    logic [7:0]            read_data;
    logic [ROM_BANK_W-1:0] rom_bank;
    logic [RAM_BANK_W-1:0] ram_bank;
  } out_item_t;

  typedef struct packed {
    logic                  start;
    logic [ROM_BANK_W-1:0] dividend;
    logic [ROM_CNT_W-1:0]  divisor;
  } mod_req_t;

  typedef struct packed {
    logic                  done;
    logic [ROM_BANK_W-1:0] remainder;
  } mod_rsp_t;

  typedef struct packed {
    logic                 tick;
    logic                 latch;
    logic                 wr_en;
    logic [RTC_SEL_W-1:0] wr_sel;
    logic [7:0]           wr_data;
    logic [RTC_SEL_W-1:0] rd_sel;
  } rtc_req_t;

endpackage

// ----- hdl/bcrtc_mod.sv -----
module bcrtc_mod
  import bcrtc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [ROM_CNT_W-1:0]  rem_r, rem_nxt;
  logic [ROM_BANK_W-1:0] dvd_r, dvd_nxt;
  logic [ROM_CNT_W-1:0]  dvs_r, dvs_nxt;
  logic [ROM_CNT_W:0]    shifted;
  logic [ROM_CNT_W:0]    diff;

  assign shifted = {rem_r, dvd_r[ROM_BANK_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      // one restoring step per cycle
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = diff[ROM_CNT_W-1:0];
      end else begin
        rem_nxt = shifted[ROM_CNT_W-1:0];
      end
      dvd_nxt = {dvd_r[ROM_BANK_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.remainder = rem_r[ROM_BANK_W-1:0];

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("remainder unit restarted while busy");
`endif

endmodule

// ----- hdl/bcrtc_rtc.sv -----
module bcrtc_rtc
  import bcrtc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  rtc_req_t   req,
  output logic [7:0] rd_data
);

  logic [5:0] sec_r, sec_nxt;
  logic [5:0] min_r, min_nxt;
  logic [4:0] hour_r, hour_nxt;
  logic [7:0] dl_r, dl_nxt;
  logic [7:0] dh_r, dh_nxt;
  logic [7:0] latched_r [LATCH_DEPTH];
  logic [8:0] days;

  assign days = {dh_r[0], dl_r};

  always_comb begin
    sec_nxt  = sec_r;
    min_nxt  = min_r;
    hour_nxt = hour_r;
    dl_nxt   = dl_r;
    dh_nxt   = dh_r;
    if (req.tick && !dh_r[HALT_BIT]) begin
      sec_nxt = (sec_r == 6'd59) ? 6'd0 : sec_r + 6'd1;
      if (sec_r == 6'd59) begin
        min_nxt = (min_r == 6'd59) ? 6'd0 : min_r + 6'd1;
        if (min_r == 6'd59) begin
          hour_nxt = (hour_r == 5'd23) ? 5'd0 : hour_r + 5'd1;
          if (hour_r == 5'd23) begin
            dl_nxt    = dl_r + 8'd1;
            dh_nxt[0] = (days == 9'd511) ? 1'b0 : days[8] | (&dl_r);
            if (days == 9'd511) begin
              dh_nxt[CARRY_BIT] = 1'b1;
            end
          end
        end
      end
    end else if (req.wr_en) begin
      unique case (req.wr_sel)
        SEL_SECONDS:   sec_nxt  = req.wr_data[5:0];
        SEL_MINUTES:   min_nxt  = req.wr_data[5:0];
        SEL_HOURS:     hour_nxt = req.wr_data[4:0];
        SEL_DAYS_LOW:  dl_nxt   = req.wr_data;
        SEL_DAYS_HIGH: dh_nxt   = req.wr_data & MASK_DAYS_HIGH;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r  <= '0;
      min_r  <= '0;
      hour_r <= '0;
      dl_r   <= '0;
      dh_r   <= '0;
      for (int i = 0; i < LATCH_DEPTH; i++) begin
        latched_r[i] <= '0;
      end
    end else begin
      sec_r  <= sec_nxt;
      min_r  <= min_nxt;
      hour_r <= hour_nxt;
      dl_r   <= dl_nxt;
      dh_r   <= dh_nxt;
      if (req.latch) begin
        latched_r[0] <= {2'b00, sec_r};
        latched_r[1] <= {2'b00, min_r};
        latched_r[2] <= {3'b000, hour_r};
        latched_r[3] <= dl_r;
        latched_r[4] <= dh_r;
      end
    end
  end

  always_comb begin
    unique case (req.rd_sel)
      SEL_SECONDS:   rd_data = latched_r[0];
      SEL_MINUTES:   rd_data = latched_r[1];
      SEL_HOURS:     rd_data = latched_r[2];
      SEL_DAYS_LOW:  rd_data = latched_r[3];
      SEL_DAYS_HIGH: rd_data = latched_r[4];
      default:       rd_data = BYTE_ONES;
    endcase
  end

`ifndef ASSERT_OFF
  a_carry_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (dh_r[CARRY_BIT] && !req.wr_en) |=> dh_r[CARRY_BIT])
    else $error("day carry cleared without a register write");
`endif

endmodule

// ----- hdl/bank_controller_with_rtc_top.sv -----
// Cartridge bank controller with real-time clock. Each in_ transfer is a bus write, a bus read
// or a one-second tick, and gives exactly one out_ transfer with the handled flag, the byte read
// or echoed, and the ROM and RAM bank in effect afterwards. in_stall is high while an item is
// in work: each item passes the execute and finish states, and writes that pick a ROM bank or
// a RAM bank also wait in the divide state for the shared remainder unit, which takes one bit
// per cycle. The result sits in an output register, so the next item is taken while it waits.
// Configuration writes are always ready and are meant for idle periods only.
module bank_controller_with_rtc_top
  import bcrtc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  in_item_t              item_r, item_nxt;
  logic [ROM_CNT_W-1:0]  rom_cnt_r, rom_cnt_nxt;
  logic [RAM_CNT_W-1:0]  ram_cnt_r, ram_cnt_nxt;
  logic                  clk_present_r, clk_present_nxt;
  logic                  ram_en_r, ram_en_nxt;
  logic [ROM_BANK_W-1:0] rom_bank_r, rom_bank_nxt;
  logic [RAM_BANK_W-1:0] ram_bank_r, ram_bank_nxt;
  logic [7:0]            win_sel_r, win_sel_nxt;
  logic                  clk_mode_r, clk_mode_nxt;
  logic [7:0]            last_latch_r, last_latch_nxt;
  logic                  handled_r, handled_nxt;
  logic [7:0]            rd_r, rd_nxt;
  logic                  div_rom_r, div_rom_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_data_r, out_data_nxt;

  mod_req_t              mod_req;
  mod_rsp_t              mod_rsp;
  rtc_req_t              rtc_req;
  logic [7:0]            rtc_rd;

  logic                  in_xfer;
  logic                  out_free;
  logic [2:0]            area;
  logic                  rtc_sel_ok;
  logic [ROM_BANK_W-1:0] rom_req;

  assign in_xfer    = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign area       = item_r.address[15:13];
  assign rtc_sel_ok = (win_sel_r[7:3] == 5'd1) && (win_sel_r[2:0] <= SEL_DAYS_HIGH);
  assign rom_req    = (item_r.data[ROM_BANK_W-1:0] == '0) ? ROM_BANK_W'(1)
                                                          : item_r.data[ROM_BANK_W-1:0];

  bcrtc_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  bcrtc_rtc u_rtc (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (rtc_req),
    .rd_data (rtc_rd)
  );

  always_comb begin
    state_nxt       = state_r;
    item_nxt        = item_r;
    rom_cnt_nxt     = rom_cnt_r;
    ram_cnt_nxt     = ram_cnt_r;
    clk_present_nxt = clk_present_r;
    ram_en_nxt      = ram_en_r;
    rom_bank_nxt    = rom_bank_r;
    ram_bank_nxt    = ram_bank_r;
    win_sel_nxt     = win_sel_r;
    clk_mode_nxt    = clk_mode_r;
    last_latch_nxt  = last_latch_r;
    handled_nxt     = handled_r;
    rd_nxt          = rd_r;
    div_rom_nxt     = div_rom_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_data_nxt    = out_data_r;

    mod_req.start    = 1'b0;
    mod_req.dividend = rom_req;
    mod_req.divisor  = rom_cnt_r;

    rtc_req.tick    = 1'b0;
    rtc_req.latch   = 1'b0;
    rtc_req.wr_en   = 1'b0;
    rtc_req.wr_sel  = win_sel_r[2:0];
    rtc_req.wr_data = item_r.data;
    rtc_req.rd_sel  = rtc_sel_ok ? win_sel_r[2:0] : SEL_NONE;

    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROM_BANK_COUNT: rom_cnt_nxt     = cfg_data;
        CFG_RAM_BANK_COUNT: ram_cnt_nxt     = cfg_data[RAM_CNT_W-1:0];
        CFG_CLOCK_PRESENT:  clk_present_nxt = cfg_data[0];
        default:            ;
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          item_nxt  = in_data;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        handled_nxt = 1'b0;
        rd_nxt      = '0;
        state_nxt   = ST_FIN;
        unique case (item_r.cmd)
          CMD_WRITE: begin
            unique case (area)
              AREA_RAM_EN: begin
                ram_en_nxt = (item_r.data[3:0] == RAM_EN_KEY);
              end
              AREA_ROM_SEL: begin
                mod_req.start = 1'b1;
                div_rom_nxt   = 1'b1;
                state_nxt     = ST_DIV;
              end
              AREA_WIN_SEL: begin
                win_sel_nxt = item_r.data;
                if (item_r.data[7:3] == 5'd0) begin
                  clk_mode_nxt     = 1'b0;
                  mod_req.start    = 1'b1;
                  mod_req.dividend = {4'd0, item_r.data[2:0]};
                  mod_req.divisor  = {5'd0, ram_cnt_r};
                  div_rom_nxt      = 1'b0;
                  state_nxt        = ST_DIV;
                end else if (clk_present_r) begin
                  clk_mode_nxt = 1'b1;
                end
              end
              AREA_LATCH: begin
                if (clk_present_r) begin
                  rtc_req.latch  = (item_r.data == 8'd1) && (last_latch_r == 8'd0);
                  last_latch_nxt = item_r.data;
                end
              end
              AREA_WINDOW: begin
                if (!ram_en_r || clk_mode_r) begin
                  handled_nxt = 1'b1;
                  rd_nxt      = item_r.data;
                end
                rtc_req.wr_en = ram_en_r && clk_mode_r && rtc_sel_ok;
              end
              default: ;
            endcase
          end
          CMD_READ: begin
            if (area == AREA_WINDOW) begin
              if (!ram_en_r) begin
                handled_nxt = 1'b1;
                rd_nxt      = BYTE_ONES;
              end else if (clk_mode_r) begin
                handled_nxt = 1'b1;
                rd_nxt      = rtc_rd;
              end
            end
          end
          CMD_TICK: begin
            rtc_req.tick = clk_present_r;
          end
          default: ;
        endcase
      end
      ST_DIV: begin
        if (mod_rsp.done) begin
          if (div_rom_r) begin
            rom_bank_nxt = mod_rsp.remainder;
          end else begin
            ram_bank_nxt = (ram_cnt_r == '0) ? '0 : mod_rsp.remainder[RAM_BANK_W-1:0];
          end
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.handled   = handled_r;
          out_data_nxt.read_data = rd_r;
          out_data_nxt.rom_bank  = rom_bank_r;
          out_data_nxt.ram_bank  = ram_bank_r;
          state_nxt              = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      rom_cnt_r     <= ROM_CNT_W'(2);
      ram_cnt_r     <= '0;
      clk_present_r <= 1'b1;
      ram_en_r      <= 1'b0;
      rom_bank_r    <= ROM_BANK_W'(1);
      ram_bank_r    <= '0;
      win_sel_r     <= '0;
      clk_mode_r    <= 1'b0;
      last_latch_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      rom_cnt_r     <= rom_cnt_nxt;
      ram_cnt_r     <= ram_cnt_nxt;
      clk_present_r <= clk_present_nxt;
      ram_en_r      <= ram_en_nxt;
      rom_bank_r    <= rom_bank_nxt;
      ram_bank_r    <= ram_bank_nxt;
      win_sel_r     <= win_sel_nxt;
      clk_mode_r    <= clk_mode_nxt;
      last_latch_r  <= last_latch_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    handled_r  <= handled_nxt;
    rd_r       <= rd_nxt;
    div_rom_r  <= div_rom_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    mod_rsp.done |-> (state_r == ST_DIV))
    else $error("remainder result outside bank select");

  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_FIN))
    else $error("result loaded outside finish step");

  a_xfer_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_EXEC))
    else $error("accepted item not executed");
`endif

endmodule

// ----- sim/bank_controller_with_rtc_top_tb.sv -----
module bank_controller_with_rtc_top_tb;
  import bcrtc_pkg::*;

  localparam logic [1:0] CMD_UNUSED         = 2'd3;
  localparam logic [2:0] AREA_UNMAPPED_LOW  = 3'd4;
  localparam logic [2:0] AREA_UNMAPPED_HIGH = 3'd7;
  localparam logic [7:0] SEL_FIRST_CLOCK    = 8'h08;
  localparam logic [7:0] SEL_LAST_CLOCK     = 8'h0C;
  localparam logic [7:0] LATCH_ARM          = 8'h00;
  localparam logic [7:0] LATCH_FIRE         = 8'h01;
  localparam int         QUIET_LIMIT        = 2000;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_ROM_BANK_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bank_controller_with_rtc_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // predicted controller state
  logic [ROM_CNT_W-1:0]  rom_count;
  logic [RAM_CNT_W-1:0]  ram_count;
  logic                  clk_present;
  logic                  ram_en;
  logic [ROM_BANK_W-1:0] rom_bank_q;
  logic [RAM_BANK_W-1:0] ram_bank_q;
  logic [7:0]            win_sel;
  logic                  rtc_mode;
  logic [7:0]            latch_prev;
  logic [5:0]            sec;
  logic [5:0]            mins;
  logic [4:0]            hrs;
  logic [7:0]            days_lo;
  logic [7:0]            days_hi;
  logic [7:0]            latched [LATCH_DEPTH];

  out_item_t expected_results [$];
  int        errors = 0;
  int        items_sent = 0;
  int        results_checked = 0;
  int        cfg_writes = 0;
  int        quiet_cycles = 0;
  bit        sender_idle_on = 1'b1;
  int        stall_left = 0;
  int        calm_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void reset_model();
    rom_count   = 10'd2;
    ram_count   = '0;
    clk_present = 1'b1;
    ram_en      = 1'b0;
    rom_bank_q  = 7'd1;
    ram_bank_q  = '0;
    win_sel     = '0;
    rtc_mode    = 1'b0;
    latch_prev  = '0;
    sec         = '0;
    mins        = '0;
    hrs         = '0;
    days_lo     = '0;
    days_hi     = '0;
    for (int i = 0; i < LATCH_DEPTH; i++) latched[i] = '0;
  endfunction

  // out-of-range units count up to the field top and wrap without carrying
  function automatic void advance_clock();
    logic [9:0] day_count;
    if (!clk_present || days_hi[HALT_BIT]) return;
    if (sec >= 6'd60) begin
      sec = sec + 1'b1;
      return;
    end
    sec = sec + 1'b1;
    if (sec != 6'd60) return;
    sec = '0;
    if (mins >= 6'd60) begin
      mins = mins + 1'b1;
      return;
    end
    mins = mins + 1'b1;
    if (mins != 6'd60) return;
    mins = '0;
    if (hrs >= 5'd24) begin
      hrs = hrs + 1'b1;
      return;
    end
    hrs = hrs + 1'b1;
    if (hrs != 5'd24) return;
    hrs = '0;
    day_count = {1'b0, days_hi[0], days_lo} + 10'd1;
    if (day_count[9]) days_hi[CARRY_BIT] = 1'b1;
    days_lo = day_count[7:0];
    days_hi[0] = day_count[8];
  endfunction

  function automatic out_item_t apply_bus_item(in_item_t it);
    out_item_t             res;
    logic [ROM_BANK_W-1:0] bank;
    logic                  in_window;
    logic                  clock_sel;
    res = '0;
    in_window = (it.address[15:13] == AREA_WINDOW);
    clock_sel = (win_sel >= SEL_FIRST_CLOCK) && (win_sel <= SEL_LAST_CLOCK);
    case (it.cmd)
      CMD_WRITE: begin
        case (it.address[15:13])
          AREA_RAM_EN: ram_en = (it.data[3:0] == RAM_EN_KEY);
          AREA_ROM_SEL: begin
            bank = it.data[6:0];
            if (bank == '0) bank = 7'd1;
            if (rom_count != '0) bank = 7'(int'(bank) % int'(rom_count));
            rom_bank_q = bank;
          end
          AREA_WIN_SEL: begin
            win_sel = it.data;
            if (it.data < SEL_FIRST_CLOCK) begin
              rtc_mode = 1'b0;
              ram_bank_q = (ram_count == '0) ? '0 : 3'(int'(it.data) % int'(ram_count));
            end else if (clk_present) begin
              rtc_mode = 1'b1;
            end
          end
          AREA_LATCH: begin
            if (clk_present) begin
              if (it.data == LATCH_FIRE && latch_prev == LATCH_ARM) begin
                latched[SEL_SECONDS]   = 8'(sec);
                latched[SEL_MINUTES]   = 8'(mins);
                latched[SEL_HOURS]     = 8'(hrs);
                latched[SEL_DAYS_LOW]  = days_lo;
                latched[SEL_DAYS_HIGH] = days_hi;
              end
              latch_prev = it.data;
            end
          end
          AREA_WINDOW: begin
            if (!ram_en || rtc_mode) begin
              res.handled = 1'b1;
              res.read_data = it.data;
              if (ram_en && clock_sel) begin
                case (3'(win_sel - SEL_FIRST_CLOCK))
                  SEL_SECONDS:   sec = it.data[5:0];
                  SEL_MINUTES:   mins = it.data[5:0];
                  SEL_HOURS:     hrs = it.data[4:0];
                  SEL_DAYS_LOW:  days_lo = it.data;
                  SEL_DAYS_HIGH: days_hi = it.data & MASK_DAYS_HIGH;
                  default: ;
                endcase
              end
            end
          end
          default: ;
        endcase
      end
      CMD_READ: begin
        if (in_window) begin
          if (!ram_en) begin
            res.handled = 1'b1;
            res.read_data = BYTE_ONES;
          end else if (rtc_mode) begin
            res.handled = 1'b1;
            res.read_data = clock_sel ? latched[3'(win_sel - SEL_FIRST_CLOCK)] : BYTE_ONES;
          end
        end
      end
      CMD_TICK: advance_clock();
      default: ;
    endcase
    res.rom_bank = rom_bank_q;
    res.ram_bank = ram_bank_q;
    return res;
  endfunction

  function automatic logic [15:0] area_addr(logic [2:0] area, logic [12:0] offset);
    return {area, offset};
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!sender_idle_on || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_item(input logic [1:0] cmd, input logic [15:0] addr,
                           input logic [7:0] dat);
    in_item_t it;
    int       gap;
    it.cmd = cmd;
    it.address = addr;
    it.data = dat;
    in_valid = 1'b1;
    in_data = it;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(apply_bus_item(it));
    items_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic bus_write(input logic [15:0] addr, input logic [7:0] dat);
    send_item(CMD_WRITE, addr, dat);
  endtask

  task automatic bus_read(input logic [15:0] addr);
    send_item(CMD_READ, addr, 8'($urandom));
  endtask

  task automatic clock_tick_item();
    send_item(CMD_TICK, 16'($urandom), 8'($urandom));
  endtask

  task automatic write_rtc_reg(input logic [2:0] sel, input logic [7:0] value);
    bus_write(area_addr(AREA_WIN_SEL, 13'($urandom)), SEL_FIRST_CLOCK + 8'(sel));
    bus_write(area_addr(AREA_WINDOW, 13'($urandom)), value);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ROM_BANK_COUNT: rom_count = ROM_CNT_W'(value);
      CFG_RAM_BANK_COUNT: ram_count = RAM_CNT_W'(value);
      CFG_CLOCK_PRESENT:  clk_present = value[0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(input int roms, input int rams, input int has_clock);
    wait_idle();
    cfg_write(CFG_ROM_BANK_COUNT, roms);
    cfg_write(CFG_RAM_BANK_COUNT, rams);
    cfg_write(CFG_CLOCK_PRESENT, has_clock);
  endtask

  task automatic test_after_reset();
    bus_read(area_addr(AREA_WINDOW, '0));
    bus_write(area_addr(AREA_WINDOW, '1), 8'h5A);
    bus_write(area_addr(AREA_ROM_SEL, '0), 8'h00);
    send_item(CMD_UNUSED, area_addr(AREA_WINDOW, '0), 8'hFF);
    bus_read(area_addr(AREA_UNMAPPED_HIGH, '1));
    bus_write(area_addr(AREA_UNMAPPED_LOW, '0), 8'hA5);
  endtask

  task automatic test_bank_limits();
    set_config(512, 16, 1);
    bus_write(area_addr(AREA_ROM_SEL, '1), 8'hFF);
    bus_write(area_addr(AREA_ROM_SEL, '0), 8'h80);
    bus_write(area_addr(AREA_WIN_SEL, '1), 8'h07);
    bus_write(area_addr(AREA_WIN_SEL, '0), 8'h00);
  endtask

  // last second of day 511 rolls into the sticky day carry
  task automatic test_clock_rollover();
    bus_write(area_addr(AREA_RAM_EN, '0), {4'h0, RAM_EN_KEY});
    write_rtc_reg(SEL_SECONDS, 8'd59);
    write_rtc_reg(SEL_MINUTES, 8'd59);
    write_rtc_reg(SEL_HOURS, 8'd23);
    write_rtc_reg(SEL_DAYS_LOW, 8'hFF);
    write_rtc_reg(SEL_DAYS_HIGH, 8'h01);
    clock_tick_item();
    bus_write(area_addr(AREA_LATCH, '0), LATCH_ARM);
    bus_write(area_addr(AREA_LATCH, '1), LATCH_FIRE);
    bus_read(area_addr(AREA_WINDOW, '1));
  endtask

  task automatic test_halt_and_bad_select();
    bus_write(area_addr(AREA_WINDOW, '0), 8'hFF);
    clock_tick_item();
    bus_write(area_addr(AREA_WIN_SEL, '0), SEL_LAST_CLOCK + 8'd1);
    bus_read(area_addr(AREA_WINDOW, '0));
    bus_write(area_addr(AREA_WINDOW, '0), 8'h33);
    bus_write(area_addr(AREA_RAM_EN, '1), 8'hF0);
  endtask

  task automatic random_sequence();
    int         r;
    int         n;
    logic [2:0] sel;
    logic [7:0] value;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      if ($urandom_range(0, 4) != 0)
        bus_write(area_addr(AREA_RAM_EN, 13'($urandom)), {4'($urandom), RAM_EN_KEY});
      sel = 3'($urandom_range(0, 4));
      value = 8'($urandom);
      case (sel)
        SEL_SECONDS, SEL_MINUTES:
          if ($urandom_range(0, 9) < 6) value = 8'($urandom_range(56, 63));
        SEL_HOURS:
          if ($urandom_range(0, 9) < 6) value = 8'($urandom_range(20, 31));
        SEL_DAYS_LOW:
          if ($urandom_range(0, 9) < 6) value = 8'($urandom_range(250, 255));
        default:
          if ($urandom_range(0, 3) != 0) value[HALT_BIT] = 1'b0;
      endcase
      write_rtc_reg(sel, value);
    end else if (r < 45) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 130) : $urandom_range(1, 8);
      repeat (n) clock_tick_item();
    end else if (r < 60) begin
      bus_write(area_addr(AREA_LATCH, 13'($urandom)),
                ($urandom_range(0, 4) == 0) ? 8'($urandom) : LATCH_ARM);
      bus_write(area_addr(AREA_LATCH, 13'($urandom)),
                ($urandom_range(0, 4) == 0) ? 8'($urandom) : LATCH_FIRE);
      value = ($urandom_range(0, 9) < 7) ? SEL_FIRST_CLOCK + 8'($urandom_range(0, 4))
                                         : 8'($urandom);
      bus_write(area_addr(AREA_WIN_SEL, 13'($urandom)), value);
      repeat ($urandom_range(1, 3)) bus_read(area_addr(AREA_WINDOW, 13'($urandom)));
    end else if (r < 75) begin
      bus_write(area_addr(AREA_ROM_SEL, 13'($urandom)), 8'($urandom));
      bus_write(area_addr(AREA_WIN_SEL, 13'($urandom)),
                ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom));
      if ($urandom_range(0, 1) == 0) bus_write(area_addr(AREA_WINDOW, 13'($urandom)),
                                               8'($urandom));
    end else if (r < 85) begin
      bus_write(area_addr(AREA_RAM_EN, 13'($urandom)),
                ($urandom_range(0, 1) == 0) ? {4'($urandom), RAM_EN_KEY} : 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 3))
        send_item(2'($urandom), 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    int roms [6]  = '{2, 512, 0, 100, 3, 127};
    int rams [6]  = '{0, 16, 1, 5, 3, 8};
    int clock [6] = '{1, 1, 0, 1, 0, 1};
    int start;
    for (int p = 0; p < 6; p++) begin
      set_config(roms[p], rams[p], clock[p]);
      sender_idle_on = (p % 3 != 1);
      start = items_sent;
      while (items_sent - start < 100) random_sequence();
    end
    sender_idle_on = 1'b1;
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h", $time, out_data);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("handled", want.handled, out_data.handled);
        check_field("read_data", want.read_data, out_data.read_data);
        check_field("rom_bank", want.rom_bank, out_data.rom_bank);
        check_field("ram_bank", want.ram_bank, out_data.ram_bank);
      end
    end
  end

  always @(negedge clk) begin : drive_out_stall
    int r;
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if (calm_left > 0) begin
      out_stall = 1'b0;
      calm_left--;
    end else begin
      r = $urandom_range(0, 99);
      out_stall = 1'b0;
      if (r < 3) begin
        calm_left = $urandom_range(50, 150);
      end else if (r < 30) begin
        out_stall = 1'b1;
        stall_left = $urandom_range(0, 2);
      end else if (r < 36) begin
        out_stall = 1'b1;
        stall_left = $urandom_range(5, 15);
      end else if (r < 37) begin
        out_stall = 1'b1;
        stall_left = $urandom_range(30, 60);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
      $display("bank_controller_with_rtc_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_after_reset();
    test_bank_limits();
    test_clock_rollover();
    test_halt_and_bad_select();
    test_random_traffic();
    wait_idle();
    repeat (20) @(negedge clk);
    $display("covered %0d bus items (writes, reads, ticks, unused codes) and %0d results",
             items_sent, results_checked);
    $display("across %0d register writes: rom counts 0..512, ram counts 0..16, clock on and off",
             cfg_writes);
    if (errors == 0 && expected_results.size() == 0)
      $display("bank_controller_with_rtc_top_tb OK");
    else
      $display("bank_controller_with_rtc_top_tb NOT OK");
    $finish;
  end

endmodule
